// ----- hw/rtl/orf_pkg.sv -----
// ============================================================================
// orf_pkg
// Shared types and constants for the overwriting ring FIFO.
// ============================================================================
`default_nettype none

package orf_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;

    // request codes carried on the action field
    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_GET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic put;
        logic get;
        logic clear;
        logic cfg_write;
        logic load_status;
        logic load_read;
    } orf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_valid;
        logic empty;
    } orf_status_t;

endpackage : orf_pkg

`default_nettype wire

// ----- hw/rtl/overwriting_ring_fifo_top.sv -----
// ============================================================================
// overwriting_ring_fifo_top
// Circular FIFO that overwrites its oldest word when a put finds it full.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: action
//   (put, get, clear; code 3 is a no-op) and write_word for a put.
//   Output channel (out_valid/out_ready) returns exactly one result word per
//   request: read_word/read_valid for a get, plus occupancy, is_empty and
//   is_full after the action.
//   Config channel (cfg_valid/cfg_ready) writes the capacity (clamped to
//   1..DEPTH) and empties the buffer; stored words are kept. Write it only
//   while no request is in flight.
// Timing:
//   put, clear, no-op and a get on an empty buffer: result in the cycle after
//   accept; one request per cycle if the output drains and cfg_valid is low.
//   get with data: registered memory read, then the result register.
//   A new request is taken while a result still sits in the output register
//   if that result is being drained the same cycle.
// Reset: pointers and full flag cleared, capacity = DEPTH, memory untouched.
// Stall: a stalled output holds its word; no new request is taken until the
//   output register frees.
// ============================================================================
`default_nettype none

module overwriting_ring_fifo_top
    import orf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    localparam int CAP_W    = $clog2(DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [WORD_BITS-1:0] write_word,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [WORD_BITS-1:0]      read_word,
    output logic                      read_valid,
    output logic [CAP_W-1:0]          occupancy,
    output logic                      is_empty,
    output logic                      is_full,
    // capacity write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CAP_W-1:0]     cfg_data
);

    orf_cmd_t    cmd;
    orf_status_t status;

    // sequencer: decodes requests, owns the read-wait state
    orf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // pointers, memory and the output word register
    orf_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .write_word (write_word),
        .cfg_data   (cfg_data),
        .out_ready  (out_ready),
        .status     (status),
        .out_valid  (out_valid),
        .read_word  (read_word),
        .read_valid (read_valid),
        .occupancy  (occupancy),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule : overwriting_ring_fifo_top

`default_nettype wire

// ----- hw/rtl/orf_ctrl.sv -----
// ============================================================================
// orf_ctrl
// Request sequencer: handshakes and command decode for the datapath.
// ============================================================================
`default_nettype none

module orf_ctrl
    import orf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        out_ready,
    input  wire orf_status_t status,
    output orf_cmd_t         cmd
);

    state_t  state_reg;
    state_t  state_next;
    action_t act;
    logic    in_fire;
    logic    slot_free;

    assign act = action_t'(action);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state: a get that finds data moves to ST_READ for the memory read
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && act == ACT_GET && !status.empty)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        slot_free = !status.out_valid || out_ready;
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = slot_free && !cfg_valid;
            end
            ST_READ:
            begin
                in_ready  = 1'b0;
                cfg_ready = 1'b0;
            end
            default:
            begin
                in_ready  = 1'b0;
                cfg_ready = 1'b0;
            end
        endcase

        in_fire         = in_valid && in_ready;
        cmd.put         = in_fire && act == ACT_PUT;
        cmd.get         = in_fire && act == ACT_GET && !status.empty;
        cmd.clear       = in_fire && act == ACT_CLEAR;
        cmd.cfg_write   = cfg_valid && cfg_ready;
        cmd.load_status = in_fire && !cmd.get;
        cmd.load_read   = (state_reg == ST_READ);
    end

endmodule : orf_ctrl

`default_nettype wire

// ----- hw/rtl/orf_dp.sv -----
// ============================================================================
// orf_dp
// Pointers, capacity register, word memory and result register.
// ============================================================================
`default_nettype none

module orf_dp
    import orf_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT,
    localparam int PTR_W    = $clog2(DEPTH),
    localparam int CAP_W    = $clog2(DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire orf_cmd_t             cmd,
    input  wire logic [WORD_BITS-1:0] write_word,
    input  wire logic [CAP_W-1:0]     cfg_data,
    input  wire logic                 out_ready,
    output orf_status_t               status,
    output logic                      out_valid,
    output logic [WORD_BITS-1:0]      read_word,
    output logic                      read_valid,
    output logic [CAP_W-1:0]          occupancy,
    output logic                      is_empty,
    output logic                      is_full
);

    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_ONE = CAP_W'(1);

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [PTR_W-1:0]     rp_reg, rp_next;
    logic                 full_reg, full_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [WORD_BITS-1:0] rdata_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] read_word_reg;
    logic                 read_valid_reg;
    logic [CAP_W-1:0]     occ_reg;
    logic                 empty_reg;
    logic                 full_out_reg;

    logic [PTR_W-1:0]     wp_adv, rp_adv;
    logic [CAP_W-1:0]     occ_next;

    // wrap by compare against the capacity
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(p) + CAP_ONE;
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    assign wp_adv = advance(wp_reg, cap_reg);
    assign rp_adv = advance(rp_reg, cap_reg);

    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        full_next = full_reg;
        cap_next  = cap_reg;
        if (cmd.cfg_write)
        begin
            wp_next   = '0;
            rp_next   = '0;
            full_next = 1'b0;
            if (cfg_data == '0)
            begin
                cap_next = CAP_ONE;
            end
            else if (cfg_data > CAP_MAX)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = cfg_data;
            end
        end
        else if (cmd.put)
        begin
            wp_next   = wp_adv;
            rp_next   = full_reg ? rp_adv : rp_reg;
            full_next = (wp_adv == rp_next);
        end
        else if (cmd.get)
        begin
            rp_next   = rp_adv;
            full_next = 1'b0;
        end
        else if (cmd.clear)
        begin
            wp_next   = rp_reg;
            full_next = 1'b0;
        end
    end

    // occupancy after the update; in the read cycle nothing moves
    always_comb
    begin
        if (full_next)
        begin
            occ_next = cap_next;
        end
        else if (wp_next >= rp_next)
        begin
            occ_next = CAP_W'(wp_next) - CAP_W'(rp_next);
        end
        else
        begin
            occ_next = cap_next + CAP_W'(wp_next) - CAP_W'(rp_next);
        end
    end

    always_comb
    begin
        if (cmd.load_status || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            full_reg      <= 1'b0;
            cap_reg       <= CAP_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            full_reg      <= full_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // word memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            mem[wp_reg] <= write_word;
        end
        if (cmd.get)
        begin
            rdata_reg <= mem[rp_reg];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_status || cmd.load_read)
        begin
            read_word_reg  <= cmd.load_read ? rdata_reg : '0;
            read_valid_reg <= cmd.load_read;
            occ_reg        <= occ_next;
            empty_reg      <= (occ_next == '0);
            full_out_reg   <= (occ_next == cap_next);
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.empty     = !full_reg && (wp_reg == rp_reg);

    assign out_valid  = out_valid_reg;
    assign read_word  = read_word_reg;
    assign read_valid = read_valid_reg;
    assign occupancy  = occ_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_out_reg;

endmodule : orf_dp

`default_nettype wire
